/* rtl/gbfw_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gbfw_pkg
// Shared types and codes of the breadth-first graph walker.
// ----------------------------------------------------------------------------
package gbfw_pkg;

  // vertex fields are four bits wide, so a walk holds at most this many vertices
  localparam int unsigned VERT_SPAN = 16;
  localparam int unsigned VERT_W    = 4;
  localparam int unsigned QPTR_W    = 5;

  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_ADD   = 2'd1;
  localparam logic [1:0] MODE_RUN   = 2'd2;

  typedef logic [VERT_W-1:0] vertex_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP,
    ST_RD,
    ST_CHK,
    ST_FIN
  } walk_state_e;

endpackage
`default_nettype wire

/* rtl/graph_breadth_first_walk_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// graph_breadth_first_walk_top
// Adjacency-list graph store with a breadth-first walker over it.
// Clear and add-edge requests are taken one per cycle.
// A run request queues the start vertex, then dequeues vertices one at a time and
// scans each list entry (neighbor memory read, then check); it closes on an empty
// queue with the last vertex out, held by any output stalls; the memory port sets the pace.
// Reset clears degrees, visited marks and queue pointers at once; no clearing pass.
// ----------------------------------------------------------------------------
module graph_breadth_first_walk_top #(
  parameter int unsigned VERTICES   = 16,
  parameter int unsigned MAX_DEGREE = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // source_vertex[3:0], target_vertex[7:4]
  input  wire logic [1:0] s_axis_tuser,   // mode[1:0]
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // visited_vertex[3:0], zero[7:4]
  output logic            m_axis_tlast    // last
);
  import gbfw_pkg::*;

  localparam int unsigned Rows   = (VERTICES < VERT_SPAN) ? VERTICES : VERT_SPAN;
  localparam int unsigned Depth  = Rows * MAX_DEGREE;
  localparam int unsigned AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned DegW   = $clog2(MAX_DEGREE + 1);

  // neighbor memory
  vertex_t              nbr_mem [Depth];
  vertex_t              rdata_q;
  logic                 mem_we, mem_re;
  logic [AddrW-1:0]     mem_waddr, mem_raddr;
  vertex_t              mem_wdata;

  // per-vertex degree and walk queue
  logic [DegW-1:0]      degree_q [VERT_SPAN];
  vertex_t              queue_q  [VERT_SPAN];
  logic                 deg_we, deg_clr;
  vertex_t              deg_waddr;
  logic [DegW-1:0]      deg_wdata;
  logic                 q_we;
  logic [VERT_W-1:0]    q_waddr;
  vertex_t              q_wdata;

  walk_state_e          state_q, state_d;
  logic [QPTR_W-1:0]    head_q, head_d, tail_q, tail_d;
  logic [DegW-1:0]      k_q, k_d, deg_q, deg_d;
  vertex_t              vert_q, vert_d, pend_q, pend_d;
  logic [VERT_SPAN-1:0] visited_q, visited_d;

  logic                 out_valid_q, out_last_q;
  vertex_t              out_vertex_q;
  logic                 out_push, out_push_last, out_free;

  vertex_t              in_src, in_dst;
  logic                 in_ack;

  assign in_src        = s_axis_tdata[3:0];
  assign in_dst        = s_axis_tdata[7:4];
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_ack        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_vertex_q};
  assign m_axis_tlast  = out_last_q;

  always_comb begin
    vertex_t         w;
    vertex_t         v;
    logic            fresh;
    logic [DegW-1:0] src_deg;
    logic [DegW-1:0] k_inc;

    state_d       = state_q;
    head_d        = head_q;
    tail_d        = tail_q;
    k_d           = k_q;
    deg_d         = deg_q;
    vert_d        = vert_q;
    pend_d        = pend_q;
    visited_d     = visited_q;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = in_dst;
    mem_re        = 1'b0;
    mem_raddr     = AddrW'(32'(vert_q) * MAX_DEGREE + 32'(k_q));
    deg_we        = 1'b0;
    deg_clr       = 1'b0;
    src_deg       = degree_q[in_src];
    deg_waddr     = in_src;
    deg_wdata     = src_deg + 1'b1;
    q_we          = 1'b0;
    q_waddr       = tail_q[VERT_W-1:0];
    q_wdata       = in_src;
    out_push      = 1'b0;
    out_push_last = 1'b0;
    w             = rdata_q;
    v             = queue_q[head_q[VERT_W-1:0]];
    fresh         = (32'(w) < VERTICES) && !visited_q[w];
    k_inc         = k_q + 1'b1;

    case (state_q)
      ST_IDLE: begin
        if (in_ack) begin
          case (s_axis_tuser)
            MODE_CLEAR: deg_clr = 1'b1;
            MODE_ADD: begin
              if ((32'(in_src) < VERTICES) && (32'(in_dst) < VERTICES) &&
                  (32'(src_deg) < MAX_DEGREE)) begin
                mem_we    = 1'b1;
                mem_waddr = AddrW'(32'(in_src) * MAX_DEGREE + 32'(src_deg));
                deg_we    = 1'b1;
              end
            end
            MODE_RUN: begin
              if (32'(in_src) < VERTICES) begin
                visited_d         = '0;
                visited_d[in_src] = 1'b1;
                q_we              = 1'b1;
                q_waddr           = '0;
                head_d            = '0;
                tail_d            = QPTR_W'(1);
                pend_d            = in_src;
                state_d           = ST_POP;
              end
            end
            default: ;
          endcase
        end
      end
      ST_POP: begin
        if (head_q == tail_q) begin
          state_d = ST_FIN;
        end else begin
          head_d = head_q + 1'b1;
          if (degree_q[v] != '0) begin
            vert_d  = v;
            deg_d   = degree_q[v];
            k_d     = '0;
            state_d = ST_RD;
          end
        end
      end
      ST_RD: begin
        mem_re  = 1'b1;
        state_d = ST_CHK;
      end
      ST_CHK: begin
        // hold the read data until the pending vertex can move out
        if (!(fresh && !out_free)) begin
          if (fresh) begin
            out_push     = 1'b1;
            pend_d       = w;
            visited_d[w] = 1'b1;
            if (!tail_q[QPTR_W-1]) begin
              q_we    = 1'b1;
              q_wdata = w;
              tail_d  = tail_q + 1'b1;
            end
          end
          if (k_inc == deg_q) begin
            state_d = ST_POP;
          end else begin
            k_d     = k_inc;
            state_d = ST_RD;
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_push      = 1'b1;
          out_push_last = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      k_q         <= '0;
      deg_q       <= '0;
      visited_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      k_q       <= k_d;
      deg_q     <= deg_d;
      visited_q <= visited_d;
      if (out_push) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    vert_q <= vert_d;
    pend_q <= pend_d;
    if (out_push) begin
      out_vertex_q <= pend_q;
      out_last_q   <= out_push_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < VERT_SPAN; i++) begin
        degree_q[i] <= '0;
      end
    end else if (deg_clr) begin
      for (int i = 0; i < VERT_SPAN; i++) begin
        degree_q[i] <= '0;
      end
    end else if (deg_we) begin
      degree_q[deg_waddr] <= deg_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_we) begin
      queue_q[q_waddr] <= q_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      nbr_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= nbr_mem[mem_raddr];
    end
  end

endmodule
`default_nettype wire

/* rtl/gbfw_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gbfw_checker
// Port-level checks of the breadth-first graph walker.
// ----------------------------------------------------------------------------
module gbfw_checker #(
  parameter int unsigned VERTICES = 16
) (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       s_axis_tvalid,
  input wire logic       s_axis_tready,
  input wire logic [7:0] s_axis_tdata,
  input wire logic [1:0] s_axis_tuser,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic       m_axis_tlast
);
  import gbfw_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // input only closes after a run request
  a_fell_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(s_axis_tready) |-> $past(s_axis_tvalid && s_axis_tuser == MODE_RUN))
    else $error("input closed without a run request");

  // clear, add and unused-mode requests never stall the next request
  a_edge_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser != MODE_RUN |=> s_axis_tready)
    else $error("input closed after a clear or add request");

  // a run from a valid start vertex starts a walk
  a_run_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == MODE_RUN &&
    (32'(s_axis_tdata[3:0]) < VERTICES) |=> !s_axis_tready)
    else $error("run request did not start a walk");

endmodule

bind graph_breadth_first_walk_top gbfw_checker #(.VERTICES(VERTICES)) u_gbfw_checker (.*);
`default_nettype wire

/* tb/tb_graph_breadth_first_walk_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb_graph_breadth_first_walk_top
// Self-checking bench for the breadth-first graph walker. A short table of
// directed requests is followed by random graph builds and walks. Every
// visited vertex is checked against an in-bench graph and walk predictor or
// against a vertex given in the table. Both stream sides idle at random, and
// the output side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_graph_breadth_first_walk_top;
  import gbfw_pkg::*;

  localparam int unsigned MAX_DEGREE     = 16;
  localparam logic [1:0]  MODE_NONE      = 2'd3;
  localparam int unsigned IDLE_LIMIT     = 4000;
  localparam int unsigned DRAIN_CYCLES   = 600;
  localparam int unsigned HOLDOFF_CYCLES = 300;
  localparam int unsigned RANDOM_ITEMS   = 410;
  localparam int unsigned ROWS           = 24;

  typedef struct packed {
    vertex_t vertex;
    logic    last;
  } visit_t;

  typedef struct packed {
    logic [1:0] mode;
    vertex_t    src;
    vertex_t    dst;
    logic [4:0] reps;          // repeated adds step the target by one
    logic       typed;         // single-vertex walk given below
    vertex_t    typed_vertex;
  } row_t;

  row_t directed_rows [ROWS] = '{
    '{MODE_RUN,   4'd5,  4'd0,  5'd1,  1'b1, 4'd5},   // walk on an empty graph
    '{MODE_RUN,   4'd0,  4'd0,  5'd1,  1'b1, 4'd0},
    '{MODE_RUN,   4'd15, 4'd15, 5'd1,  1'b1, 4'd15},
    '{MODE_NONE,  4'd15, 4'd15, 5'd1,  1'b0, 4'd0},   // unused mode, ignored
    '{MODE_ADD,   4'd0,  4'd15, 5'd1,  1'b0, 4'd0},
    '{MODE_ADD,   4'd0,  4'd0,  5'd1,  1'b0, 4'd0},   // self loop
    '{MODE_ADD,   4'd0,  4'd15, 5'd1,  1'b0, 4'd0},   // duplicate edge
    '{MODE_ADD,   4'd15, 4'd1,  5'd1,  1'b0, 4'd0},
    '{MODE_ADD,   4'd1,  4'd0,  5'd1,  1'b0, 4'd0},
    '{MODE_ADD,   4'd1,  4'd2,  5'd1,  1'b0, 4'd0},
    '{MODE_ADD,   4'd2,  4'd3,  5'd1,  1'b0, 4'd0},
    '{MODE_RUN,   4'd0,  4'd0,  5'd1,  1'b0, 4'd0},
    '{MODE_RUN,   4'd3,  4'd0,  5'd1,  1'b1, 4'd3},   // no outgoing edges
    '{MODE_ADD,   4'd4,  4'd5,  5'd17, 1'b0, 4'd0},   // fills the list, last add dropped
    '{MODE_RUN,   4'd4,  4'd0,  5'd1,  1'b0, 4'd0},   // reaches all sixteen vertices
    '{MODE_RUN,   4'd15, 4'd0,  5'd1,  1'b0, 4'd0},
    '{MODE_CLEAR, 4'd0,  4'd0,  5'd1,  1'b0, 4'd0},
    '{MODE_RUN,   4'd4,  4'd0,  5'd1,  1'b1, 4'd4},
    '{MODE_RUN,   4'd0,  4'd0,  5'd1,  1'b1, 4'd0},
    '{MODE_ADD,   4'd15, 4'd15, 5'd1,  1'b0, 4'd0},
    '{MODE_RUN,   4'd15, 4'd0,  5'd1,  1'b1, 4'd15},  // only a self loop
    '{MODE_ADD,   4'd15, 4'd0,  5'd1,  1'b0, 4'd0},
    '{MODE_NONE,  4'd0,  4'd0,  5'd1,  1'b0, 4'd0},
    '{MODE_RUN,   4'd15, 4'd0,  5'd1,  1'b0, 4'd0}
  };

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic [7:0] s_axis_tdata  = 8'd0;
  logic [1:0] s_axis_tuser  = 2'd0;
  logic       m_axis_tready = 1'b0;
  wire logic  s_axis_tready;
  wire logic  m_axis_tvalid;
  wire logic [7:0] m_axis_tdata;
  wire logic  m_axis_tlast;

  // graph as the block should hold it
  vertex_t     adj_list [VERT_SPAN][MAX_DEGREE];
  int unsigned degree [VERT_SPAN];

  visit_t pending_visits [$];

  int unsigned error_count    = 0;
  int unsigned items_sent     = 0;
  int unsigned walks_sent     = 0;
  int unsigned visits_checked = 0;
  int unsigned dropped_adds   = 0;
  int unsigned random_items   = 0;
  bit          holdoff_armed  = 1'b0;
  bit          tx_calm        = 1'b0;

  graph_breadth_first_walk_top #(
    .VERTICES  (16),
    .MAX_DEGREE(MAX_DEGREE)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what);
    error_count++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // visiting order of a breadth-first walk over the held graph
  function automatic void queue_walk_order(input vertex_t start);
    logic [VERT_SPAN-1:0] seen;
    vertex_t              fifo [VERT_SPAN];
    int unsigned          head;
    int unsigned          tail;
    vertex_t              v;
    vertex_t              w;
    seen          = '0;
    seen[start]   = 1'b1;
    fifo[0]       = start;
    head          = 0;
    tail          = 1;
    pending_visits.push_back('{vertex: start, last: 1'b0});
    while (head < tail) begin
      v = fifo[head];
      head++;
      for (int unsigned k = 0; k < degree[v]; k++) begin
        w = adj_list[v][k];
        if (!seen[w]) begin
          seen[w] = 1'b1;
          fifo[tail] = w;
          tail++;
          pending_visits.push_back('{vertex: w, last: 1'b0});
        end
      end
    end
    pending_visits[pending_visits.size()-1].last = 1'b1;
  endfunction

  function automatic void predict_request(input logic [1:0] mode, input vertex_t src,
                                          input vertex_t dst);
    case (mode)
      MODE_CLEAR: begin
        foreach (degree[i]) degree[i] = 0;
      end
      MODE_ADD: begin
        if (degree[src] < MAX_DEGREE) begin
          adj_list[src][degree[src]] = dst;
          degree[src]++;
        end else begin
          dropped_adds++;
        end
      end
      MODE_RUN: queue_walk_order(src);
      default: ;
    endcase
  endfunction

  task automatic send_request(input logic [1:0] mode, input vertex_t src, input vertex_t dst,
                              input logic typed, input vertex_t typed_vertex);
    while (!tx_calm && $urandom_range(99) < 34) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    if (typed) begin
      pending_visits.push_back('{vertex: typed_vertex, last: 1'b1});
    end else begin
      predict_request(mode, src, dst);
    end
    if (mode == MODE_RUN) walks_sent++;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {dst, src};
    s_axis_tuser  <= mode;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
  endtask

  function automatic vertex_t pick_vertex(input int unsigned base, input int unsigned span);
    return vertex_t'(base + $urandom_range(span - 1));
  endfunction

  // output side: checks results, idles at random, holds off once on request
  initial begin
    int unsigned rx_cycle;
    int unsigned holdoff_left;
    visit_t      want;
    rx_cycle     = 0;
    holdoff_left = 0;
    forever begin
      @(posedge clk_i);
      rx_cycle++;
      if (m_axis_tvalid && m_axis_tready) begin
        visits_checked++;
        if (pending_visits.size() == 0) begin
          report_mismatch($sformatf("vertex %0d with no walk pending", m_axis_tdata[3:0]));
        end else begin
          want = pending_visits.pop_front();
          if (m_axis_tdata[3:0] != want.vertex)
            report_mismatch($sformatf("vertex %0d, want %0d", m_axis_tdata[3:0], want.vertex));
          if (m_axis_tlast != want.last)
            report_mismatch($sformatf("last %0b on vertex %0d, want %0b",
                                      m_axis_tlast, m_axis_tdata[3:0], want.last));
          if (m_axis_tdata[7:4] != 4'd0)
            report_mismatch($sformatf("pad bits %0h not zero", m_axis_tdata[7:4]));
        end
      end
      if (holdoff_left == 0 && holdoff_armed) begin
        holdoff_armed = 1'b0;
        holdoff_left  = HOLDOFF_CYCLES;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        m_axis_tready <= 1'b0;
      end else if (rx_cycle >= 4000 && rx_cycle < 7000) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= 34);
      end
    end
  end

  // no request or result moving for too long means the block is stuck
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("timeout: nothing moved for %0d cycles", IDLE_LIMIT);
    $display("status: fail");
    $finish;
  end

  initial begin
    int unsigned pick;
    int unsigned base;
    int unsigned span;
    vertex_t     hub;
    bit          holdoff_used;
    holdoff_used = 1'b0;
    foreach (degree[i]) degree[i] = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      for (int unsigned i = 0; i < directed_rows[r].reps; i++) begin
        send_request(directed_rows[r].mode, directed_rows[r].src,
                     vertex_t'(directed_rows[r].dst + i), directed_rows[r].typed,
                     directed_rows[r].typed_vertex);
      end
    end

    // random graph builds followed by walks, with clears and unused-mode noise
    while (random_items < RANDOM_ITEMS) begin
      tx_calm = (random_items >= 200 && random_items < 300);
      if (random_items >= 120 && !holdoff_used) begin
        holdoff_used  = 1'b1;
        holdoff_armed = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 8) begin
        send_request(MODE_NONE, vertex_t'($urandom_range(15)), vertex_t'($urandom_range(15)),
                     1'b0, 4'd0);
      end else if (pick < 16) begin
        send_request(MODE_CLEAR, vertex_t'($urandom_range(15)), vertex_t'($urandom_range(15)),
                     1'b0, 4'd0);
        random_items++;
      end else begin
        base = $urandom_range(15);
        span = $urandom_range(2, 16);
        repeat ($urandom_range(0, 20)) begin
          send_request(MODE_ADD, pick_vertex(base, span), pick_vertex(base, span), 1'b0, 4'd0);
          random_items++;
        end
        if ($urandom_range(9) == 0) begin
          // overfill one list so that adds get dropped
          hub = pick_vertex(base, span);
          repeat ($urandom_range(16, 20)) begin
            send_request(MODE_ADD, hub, vertex_t'($urandom_range(15)), 1'b0, 4'd0);
            random_items++;
          end
        end
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(3) == 0)
            send_request(MODE_RUN, vertex_t'($urandom_range(15)), vertex_t'($urandom_range(15)),
                         1'b0, 4'd0);
          else
            send_request(MODE_RUN, pick_vertex(base, span), vertex_t'($urandom_range(15)),
                         1'b0, 4'd0);
          random_items++;
        end
      end
    end
    tx_calm = 1'b0;
    s_axis_tvalid <= 1'b0;

    while (pending_visits.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d requests, %0d walks, %0d visited vertices checked",
             items_sent, walks_sent, visits_checked);
    $display("adds dropped on full lists: %0d, mismatches: %0d", dropped_adds, error_count);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
